@@ rtl/bmf_pkg.sv @@
`timescale 1ns / 1ps

package bmf_pkg;

  // Sizes of the line stores and of the data path.
  localparam int MAX_WIDTH   = 1024;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS  = 11;
  localparam int ROW_BITS    = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int COLSUM_BITS = SAMPLE_BITS + 2;
  localparam int SUM_BITS    = SAMPLE_BITS + 4;
  localparam int MAG_BITS    = SUM_BITS - 1 + FRAC_BITS;
  localparam int MEAN_BITS   = 24;

  // Reciprocals for exact floor division by 3 and by 9 after a 33-bit shift.
  localparam int RECIP_BITS  = 32;
  localparam int RECIP_SHIFT = 33;
  localparam logic [RECIP_BITS-1:0] RECIP3 = 32'hAAAA_AAAB;
  localparam logic [RECIP_BITS-1:0] RECIP9 = 32'h38E3_8E39;
  localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;

  // Configuration register addresses (word index) and reset values.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = 16'd1;

  // The four result positions an input word can complete, in output order.
  typedef enum logic [1:0] {
    RES_ABOVE_LEFT = 2'd0,
    RES_ABOVE_LAST = 2'd1,
    RES_CUR_LEFT   = 2'd2,
    RES_CUR_LAST   = 2'd3
  } res_sel_t;

  // Commands from the controller to the data path.
  typedef struct packed {
    logic     capture;
    logic     read;
    logic     update;
    logic     div_prep;
    logic     div_mul;
    logic     load_out;
    res_sel_t sel;
    logic     last;
  } bmf_cmd_t;

  // Status from the data path to the controller.
  typedef struct packed {
    logic [3:0] res_mask;
  } bmf_stat_t;

endpackage

@@ rtl/bmf_datapath.sv @@
`timescale 1ns / 1ps

module bmf_datapath import bmf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bmf_cmd_t                      cmd,
  output bmf_stat_t                     stat,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          cfg_wr,
  input  logic                          cfg_addr,
  input  logic [31:0]                   cfg_wdata,
  output logic [31:0]                   cfg_rdata,
  output logic signed [MEAN_BITS-1:0]   out_mean_value,
  output logic [ROW_BITS-1:0]           out_row,
  output logic [COL_BITS-1:0]           out_col,
  output logic                          out_last_of_run,
  output logic                          out_frame_done
);

  // Configuration registers.
  logic [WIDTH_BITS-1:0] frame_width_r;
  logic [ROW_BITS-1:0]   frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (cfg_addr == REG_WIDTH) frame_width_r <= cfg_wdata[WIDTH_BITS-1:0];
      else frame_height_r <= cfg_wdata[ROW_BITS-1:0];
    end
  end

  assign cfg_rdata = (cfg_addr == REG_WIDTH) ? {{(32-WIDTH_BITS){1'b0}}, frame_width_r}
                                             : {{(32-ROW_BITS){1'b0}}, frame_height_r};

  // Width and height as used: zero counts as one, width is capped.
  logic [WIDTH_BITS-1:0] w_eff;
  logic [ROW_BITS-1:0]   h_eff;

  always_comb begin
    w_eff = frame_width_r;
    if (frame_width_r == '0) w_eff = WIDTH_BITS'(1);
    else if (frame_width_r > WIDTH_BITS'(MAX_WIDTH)) w_eff = WIDTH_BITS'(MAX_WIDTH);
    h_eff = (frame_height_r == '0) ? ROW_BITS'(1) : frame_height_r;
  end

  // Position counters and the captured sample.
  logic [ROW_BITS-1:0]          row_cnt_r;
  logic [COL_BITS-1:0]          col_cnt_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) sample_r <= in_sample;
  end

  // Line stores: the rows two above and one above the current row.
  logic [SAMPLE_BITS-1:0] upper_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] middle_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] upper_rd_r;
  logic [SAMPLE_BITS-1:0] middle_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      upper_rd_r  <= upper_mem[col_cnt_r];
      middle_rd_r <= middle_mem[col_cnt_r];
    end
    if (cmd.update) begin
      upper_mem[col_cnt_r]  <= middle_rd_r;
      middle_mem[col_cnt_r] <= sample_r;
    end
  end

  // Column sums entering the window, and end-of-row and end-of-frame flags.
  logic signed [COLSUM_BITS-1:0] top_ext, mid_ext, x_ext;
  logic                          last_col, last_row;
  logic [3:0]                    mask_nxt;

  always_comb begin
    x_ext    = COLSUM_BITS'(sample_r);
    mid_ext  = (row_cnt_r >= ROW_BITS'(1)) ? COLSUM_BITS'($signed(middle_rd_r)) : '0;
    top_ext  = (row_cnt_r >= ROW_BITS'(2)) ? COLSUM_BITS'($signed(upper_rd_r)) : '0;
    last_col = ({1'b0, col_cnt_r} + (COL_BITS+1)'(1)) >= w_eff;
    last_row = ({1'b0, row_cnt_r} + (ROW_BITS+1)'(1)) >= {1'b0, h_eff};
    mask_nxt[RES_ABOVE_LEFT] = (row_cnt_r != '0) && (col_cnt_r != '0);
    mask_nxt[RES_ABOVE_LAST] = (row_cnt_r != '0) && last_col;
    mask_nxt[RES_CUR_LEFT]   = last_row && (col_cnt_r != '0);
    mask_nxt[RES_CUR_LAST]   = last_row && last_col;
  end

  // Window update, position snapshot and counter advance.
  logic signed [COLSUM_BITS-1:0] wc_r [6];
  logic [ROW_BITS-1:0]           pos_row_r;
  logic [COL_BITS-1:0]           pos_col_r;
  logic [3:0]                    mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      mask_r    <= '0;
      for (int i = 0; i < 6; i++) wc_r[i] <= '0;
    end else if (cmd.update) begin
      wc_r[0]   <= wc_r[1];
      wc_r[1]   <= wc_r[2];
      wc_r[2]   <= top_ext + mid_ext + x_ext;
      wc_r[3]   <= wc_r[4];
      wc_r[4]   <= wc_r[5];
      wc_r[5]   <= mid_ext + x_ext;
      pos_row_r <= row_cnt_r;
      pos_col_r <= col_cnt_r;
      mask_r    <= mask_nxt;
      if (last_col) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row ? '0 : row_cnt_r + ROW_BITS'(1);
      end else begin
        col_cnt_r <= col_cnt_r + COL_BITS'(1);
      end
    end
  end

  assign stat.res_mask = mask_r;

  // Pick the sum, divisor factors and position of the selected result.
  logic signed [SUM_BITS-1:0] t0, t1, t2, sum_sel;
  logic [1:0]                 rows_n, cols_n;
  logic [ROW_BITS-1:0]        r_row;
  logic [COL_BITS-1:0]        r_col;
  logic                       r_done;
  logic                       col_ge1, col_ge2;

  always_comb begin
    col_ge1 = (pos_col_r >= COL_BITS'(1));
    col_ge2 = (pos_col_r >= COL_BITS'(2));
    t0 = '0;
    t1 = '0;
    t2 = '0;
    rows_n = 2'd1;
    cols_n = 2'd1;
    r_row  = pos_row_r;
    r_col  = pos_col_r;
    r_done = 1'b0;
    case (cmd.sel)
      RES_ABOVE_LEFT: begin
        t0 = SUM_BITS'(wc_r[1]);
        t1 = SUM_BITS'(wc_r[2]);
        t2 = col_ge2 ? SUM_BITS'(wc_r[0]) : '0;
        rows_n = (pos_row_r >= ROW_BITS'(2)) ? 2'd3 : 2'd2;
        cols_n = col_ge2 ? 2'd3 : 2'd2;
        r_row  = pos_row_r - ROW_BITS'(1);
        r_col  = pos_col_r - COL_BITS'(1);
      end
      RES_ABOVE_LAST: begin
        t0 = SUM_BITS'(wc_r[2]);
        t1 = col_ge1 ? SUM_BITS'(wc_r[1]) : '0;
        rows_n = (pos_row_r >= ROW_BITS'(2)) ? 2'd3 : 2'd2;
        cols_n = col_ge1 ? 2'd2 : 2'd1;
        r_row  = pos_row_r - ROW_BITS'(1);
      end
      RES_CUR_LEFT: begin
        t0 = SUM_BITS'(wc_r[4]);
        t1 = SUM_BITS'(wc_r[5]);
        t2 = col_ge2 ? SUM_BITS'(wc_r[3]) : '0;
        rows_n = (pos_row_r >= ROW_BITS'(1)) ? 2'd2 : 2'd1;
        cols_n = col_ge2 ? 2'd3 : 2'd2;
        r_col  = pos_col_r - COL_BITS'(1);
      end
      default: begin
        t0 = SUM_BITS'(wc_r[5]);
        t1 = col_ge1 ? SUM_BITS'(wc_r[4]) : '0;
        rows_n = (pos_row_r >= ROW_BITS'(1)) ? 2'd2 : 2'd1;
        cols_n = col_ge1 ? 2'd2 : 2'd1;
        r_done = 1'b1;
      end
    endcase
    sum_sel = t0 + t1 + t2;
  end

  // Divisor is 2^a * 3^b: the power of two becomes a shift, the rest a
  // reciprocal multiply. The sign is split off so truncation goes toward zero.
  logic [SUM_BITS-1:0] abs_sum;
  logic [MAG_BITS-1:0] scaled;
  logic [1:0]          pow2_n;
  logic [1:0]          threes_n;

  always_comb begin
    abs_sum  = sum_sel[SUM_BITS-1] ? SUM_BITS'(-sum_sel) : SUM_BITS'(sum_sel);
    scaled   = {abs_sum[SUM_BITS-2:0], {FRAC_BITS{1'b0}}};
    pow2_n   = 2'((rows_n == 2'd2)) + 2'((cols_n == 2'd2));
    threes_n = 2'((rows_n == 2'd3)) + 2'((cols_n == 2'd3));
  end

  logic [MAG_BITS-1:0]  mag_r;
  logic                 neg_r;
  logic [1:0]           threes_r;
  logic [ROW_BITS-1:0]  res_row_r;
  logic [COL_BITS-1:0]  res_col_r;
  logic                 res_done_r;
  logic [PROD_BITS-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (cmd.div_prep) begin
      mag_r      <= scaled >> pow2_n;
      neg_r      <= sum_sel[SUM_BITS-1];
      threes_r   <= threes_n;
      res_row_r  <= r_row;
      res_col_r  <= r_col;
      res_done_r <= r_done;
    end
    if (cmd.div_mul) begin
      prod_r <= PROD_BITS'(mag_r) * PROD_BITS'((threes_r == 2'd2) ? RECIP9 : RECIP3);
    end
  end

  // Quotient, sign restore and output register.
  logic [MAG_BITS-1:0]        quot;
  logic signed [MAG_BITS:0]   mean_full;

  always_comb begin
    quot      = (threes_r == 2'd0) ? mag_r : MAG_BITS'(prod_r >> RECIP_SHIFT);
    mean_full = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_mean_value  <= mean_full[MEAN_BITS-1:0];
      out_row         <= res_row_r;
      out_col         <= res_col_r;
      out_last_of_run <= cmd.last;
      out_frame_done  <= res_done_r;
    end
  end

endmodule

@@ rtl/bmf_ctrl.sv @@
`timescale 1ns / 1ps

module bmf_ctrl import bmf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bmf_stat_t stat,
  output bmf_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_SCAN,
    S_PREP,
    S_MUL,
    S_LOAD,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] pend_r, pend_nxt;
  res_sel_t   sel_r, sel_nxt;
  res_sel_t   first_sel;

  // Lowest pending result comes out first.
  always_comb begin
    if (pend_r[RES_ABOVE_LEFT])      first_sel = RES_ABOVE_LEFT;
    else if (pend_r[RES_ABOVE_LAST]) first_sel = RES_ABOVE_LAST;
    else if (pend_r[RES_CUR_LEFT])   first_sel = RES_CUR_LEFT;
    else                             first_sel = RES_CUR_LAST;
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.sel   = sel_r;
    cmd.last  = (pend_r == '0);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        pend_nxt  = stat.res_mask;
        state_nxt = (stat.res_mask == '0) ? S_IDLE : S_PREP;
      end
      S_PREP: begin
        cmd.div_prep       = 1'b1;
        cmd.sel            = first_sel;
        sel_nxt            = first_sel;
        pend_nxt[first_sel] = 1'b0;
        state_nxt          = S_MUL;
      end
      S_MUL: begin
        cmd.div_mul = 1'b1;
        state_nxt   = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_out = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = (pend_r == '0) ? S_IDLE : S_PREP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= '0;
      sel_r   <= RES_ABOVE_LEFT;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

@@ rtl/box_mean_filter_3x3.sv @@
`timescale 1ns / 1ps

// 3x3 box mean filter over a raster-order stream of signed 16-bit samples.
// Each mean covers the neighbors inside the frame, divided by their count,
// as signed fixed point with 8 fraction bits, truncated toward zero. A
// position's mean comes out when the sample below and to the right of it
// arrives, at the end of its row, or with the last row itself; one input
// word yields zero to four result words, and last_of_run marks the final
// one. Each input word is captured and the line stores are read and updated;
// each result word is then selected and scaled, multiplied by a reciprocal,
// put in the output register and held while out_ready is low. The next input
// word is taken once the last result word of the previous one is accepted.
// Frame width and height sit at APB byte addresses 0 and 4; the user must
// write them only between frames while the block is idle; it does not check.
module box_mean_filter_3x3 import bmf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [MEAN_BITS-1:0]   out_mean_value,
  output logic [ROW_BITS-1:0]           out_row,
  output logic [COL_BITS-1:0]           out_col,
  output logic                          out_last_of_run,
  output logic                          out_frame_done,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  bmf_cmd_t  cmd;
  bmf_stat_t stat;
  logic      cfg_wr;

  // Register access completes in the APB access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  bmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bmf_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_sample       (in_sample),
    .cfg_wr          (cfg_wr),
    .cfg_addr        (paddr[2]),
    .cfg_wdata       (pwdata),
    .cfg_rdata       (prdata),
    .out_mean_value  (out_mean_value),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

endmodule

@@ rtl/bmf_checker.sv @@
`timescale 1ns / 1ps

module bmf_checker import bmf_pkg::*; (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [MEAN_BITS-1:0] out_mean_value,
  input logic                        out_last_of_run,
  input logic                        out_frame_done
);

  // A stalled result word keeps its valid.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_mean_value))
    else $error("result value changed while stalled");

  // One input word is worked on at a time: no input is taken right after one.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous word still in work");

  // No input is taken while a result word is shown.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result word is pending");

  // The frame's final position is always the last result of its input word.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_of_run)
    else $error("frame end not marked as last result of its word");

endmodule

bind box_mean_filter_3x3 bmf_checker u_bmf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_mean_value  (out_mean_value),
  .out_last_of_run (out_last_of_run),
  .out_frame_done  (out_frame_done)
);

@@ tb/box_mean_filter_3x3_tb.sv @@
`timescale 1ns / 1ps

module box_mean_filter_3x3_tb;
  import bmf_pkg::*;

  // One mean word as it leaves the block.
  typedef struct {
    logic signed [MEAN_BITS-1:0] mean;
    logic [ROW_BITS-1:0]         row;
    logic [COL_BITS-1:0]         col;
    logic                        last;
    logic                        done;
  } mean_word_t;

  // Predicts the means of the 3x3 filter and checks the words that come out.
  class mean_scoreboard;
    logic signed [SAMPLE_BITS-1:0]   upper_line[MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0]   middle_line[MAX_WIDTH];
    logic signed [SAMPLE_BITS+1:0]   sum3_cols[3];
    logic signed [SAMPLE_BITS+1:0]   sum2_cols[3];
    logic [ROW_BITS-1:0]             row_pos;
    logic [COL_BITS-1:0]             col_pos;
    logic [WIDTH_BITS-1:0]           frame_width;
    logic [ROW_BITS-1:0]             frame_height;
    mean_word_t                      expected_means[$];
    int                              mismatches;

    function new();
      foreach (sum3_cols[i]) begin
        sum3_cols[i] = '0;
        sum2_cols[i] = '0;
      end
      row_pos = '0;
      col_pos = '0;
      frame_width = WIDTH_RESET;
      frame_height = HEIGHT_RESET;
      mismatches = 0;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, what);
    endtask

    // The mean is truncated toward zero, as SystemVerilog division does.
    function void add_mean(int sum, int count, int r, int c, bit done);
      mean_word_t m;
      int q;
      q = (sum * (1 << FRAC_BITS)) / count;
      m.mean = q[MEAN_BITS-1:0];
      m.row = r[ROW_BITS-1:0];
      m.col = c[COL_BITS-1:0];
      m.last = 1'b0;
      m.done = done;
      expected_means.push_back(m);
    endfunction

    // Works out every mean that an accepted sample completes.
    function void note_sample(logic signed [SAMPLE_BITS-1:0] x);
      int w, h, r, c, rows_up, first;
      logic signed [SAMPLE_BITS-1:0] top, mid;
      bit lastc, lastr;
      w = (frame_width == 0) ? 1 : (frame_width > MAX_WIDTH) ? MAX_WIDTH : frame_width;
      h = (frame_height == 0) ? 1 : frame_height;
      r = row_pos;
      c = col_pos;
      top = (r >= 2) ? upper_line[c] : '0;
      mid = (r >= 1) ? middle_line[c] : '0;

      // Column sums over three rows and over the lower two rows.
      sum3_cols[0] = sum3_cols[1];
      sum3_cols[1] = sum3_cols[2];
      sum3_cols[2] = top + mid + x;
      sum2_cols[0] = sum2_cols[1];
      sum2_cols[1] = sum2_cols[2];
      sum2_cols[2] = mid + x;
      upper_line[c] = middle_line[c];
      middle_line[c] = x;

      lastc = (c + 1 >= w);
      lastr = (r + 1 >= h);
      first = expected_means.size();

      // Means of the row above, centered one column back and at the row end.
      if (r >= 1) begin
        rows_up = (r >= 2) ? 3 : 2;
        if (c >= 1)
          add_mean(int'(sum3_cols[1]) + int'(sum3_cols[2]) +
                   ((c >= 2) ? int'(sum3_cols[0]) : 0),
                   rows_up * ((c >= 2) ? 3 : 2), r - 1, c - 1, 1'b0);
        if (lastc)
          add_mean(int'(sum3_cols[2]) + ((c >= 1) ? int'(sum3_cols[1]) : 0),
                   rows_up * ((c >= 1) ? 2 : 1), r - 1, c, 1'b0);
      end

      // On the last row the current row's means come out at once.
      if (lastr) begin
        rows_up = (r >= 1) ? 2 : 1;
        if (c >= 1)
          add_mean(int'(sum2_cols[1]) + int'(sum2_cols[2]) +
                   ((c >= 2) ? int'(sum2_cols[0]) : 0),
                   rows_up * ((c >= 2) ? 3 : 2), r, c - 1, 1'b0);
        if (lastc)
          add_mean(int'(sum2_cols[2]) + ((c >= 1) ? int'(sum2_cols[1]) : 0),
                   rows_up * ((c >= 1) ? 2 : 1), r, c, 1'b1);
      end
      if (expected_means.size() > first)
        expected_means[expected_means.size() - 1].last = 1'b1;

      if (lastc) begin
        col_pos = '0;
        row_pos = lastr ? '0 : row_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
    endfunction

    task check_result(mean_word_t got);
      mean_word_t want;
      if (expected_means.size() == 0) begin
        report_mismatch($sformatf("unexpected word at row %0d col %0d", got.row, got.col));
        return;
      end
      want = expected_means.pop_front();
      if (got.mean !== want.mean)
        report_mismatch($sformatf("row %0d col %0d mean %0d, expected %0d",
                                  want.row, want.col, got.mean, want.mean));
      if (got.row !== want.row)
        report_mismatch($sformatf("row index %0d, expected %0d", got.row, want.row));
      if (got.col !== want.col)
        report_mismatch($sformatf("column index %0d, expected %0d", got.col, want.col));
      if (got.last !== want.last)
        report_mismatch($sformatf("row %0d col %0d last_of_run %b, expected %b",
                                  want.row, want.col, got.last, want.last));
      if (got.done !== want.done)
        report_mismatch($sformatf("row %0d col %0d frame_done %b, expected %b",
                                  want.row, want.col, got.done, want.done));
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [MEAN_BITS-1:0]   out_mean_value;
  logic [ROW_BITS-1:0]           out_row;
  logic [COL_BITS-1:0]           out_col;
  logic                          out_last_of_run;
  logic                          out_frame_done;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [2:0]                    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  mean_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int random_sent;

  box_mean_filter_3x3 dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mean_value  (out_mean_value),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver decides at each falling edge whether to take a word.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted mean word goes to the scoreboard.
  always @(posedge clk) begin
    mean_word_t got;
    if (rst_n && out_valid && out_ready) begin
      got.mean = out_mean_value;
      got.row = out_row;
      got.col = out_col;
      got.last = out_last_of_run;
      got.done = out_frame_done;
      sb.check_result(got);
    end
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Drops valid and waits until every expected word has come out.
  task automatic drain_means();
    in_valid = 1'b0;
    while (sb.expected_means.size() != 0) @(negedge clk);
  endtask

  // Frame size changes only with the block idle and the frame complete.
  task automatic set_frame(input int w, input int h);
    drain_means();
    repeat (16) @(negedge clk);
    apb_write({REG_WIDTH, 2'b00}, w);
    sb.frame_width = w[WIDTH_BITS-1:0];
    apb_write({REG_HEIGHT, 2'b00}, h);
    sb.frame_height = h[ROW_BITS-1:0];
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = value;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(value);
    @(negedge clk);
  endtask

  // Extremes are weighted up so that full-scale sums show up often.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: pick_sample = 16'sh7FFF;
      1: pick_sample = 16'sh8000;
      2: pick_sample = $urandom_range(1) ? 16'sh0000 : 16'shFFFF;
      default: pick_sample = SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // Whole frames of random size and content, with a drain pause now and then.
  task automatic random_frames(input int goal);
    int sent, w, h, weff, heff;
    sent = 0;
    while (sent < goal) begin
      case ($urandom_range(9))
        0: w = 0;
        1: w = $urandom_range(9, 40);
        default: w = $urandom_range(1, 8);
      endcase
      h = (w > 8) ? $urandom_range(0, 2) : $urandom_range(0, 6);
      weff = (w == 0) ? 1 : w;
      heff = (h == 0) ? 1 : h;
      set_frame(w, h);
      repeat (weff * heff) begin
        if (random_sent == 50 || $urandom_range(39) == 0) drain_means();
        send_sample(pick_sample());
        sent++;
        random_sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 36;
    recv_idle_pct = 71;
    random_sent = 0;
    sb = new();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Zero sizes count as one: single-sample frames at both extremes.
    set_frame(0, 0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);

    // A 3x3 frame at full scale each way covers corner, edge and center counts.
    set_frame(3, 3);
    repeat (9) send_sample(16'sh7FFF);
    repeat (9) send_sample(16'sh8000);

    // A single column gives the counts of three and two.
    set_frame(1, 3);
    send_sample(16'shFFFF);
    send_sample(16'sh0001);
    send_sample(16'sh7FFF);

    random_frames(80);

    send_idle_pct = 71;
    recv_idle_pct = 36;
    random_frames(80);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_frames(80);

    // Tallest frame, only its first rows.
    set_frame(1, 65535);
    repeat (40) send_sample(pick_sample());

    drain_means();
    repeat (40) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bmf_pkg.sv
rtl/bmf_datapath.sv
rtl/bmf_ctrl.sv
rtl/box_mean_filter_3x3.sv
rtl/bmf_checker.sv
tb/box_mean_filter_3x3_tb.sv
